// ===== rtl/swmc_pkg.sv =====
package swmc_pkg;

  localparam int SAMPLE_W       = 31;
  localparam int COST_W         = 39;
  localparam int CFG_W          = 9;
  localparam int WINDOW_MAX_DEF = 256;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 72;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// ===== rtl/swmc_cell.sv =====
module swmc_cell #(
  parameter int AGE_W = 8
) (
  input  logic                          clk,
  input  swmc_pkg::cell_ctl_t           ctl,
  input  logic [swmc_pkg::SAMPLE_W-1:0] v,
  input  logic [swmc_pkg::SAMPLE_W-1:0] r,
  input  logic                          valid,
  input  logic                          left_le,
  input  logic [swmc_pkg::SAMPLE_W-1:0] left_val,
  input  logic [AGE_W-1:0]              left_age,
  input  logic [swmc_pkg::SAMPLE_W-1:0] right_val,
  input  logic [AGE_W-1:0]              right_age,
  output logic [swmc_pkg::SAMPLE_W-1:0] val,
  output logic [AGE_W-1:0]              age,
  output logic                          le
);

  assign le = valid && (val <= v);

  // An insert shifts the row right above the insertion point; a removal
  // shifts it left from the first entry that is not below the leaving value.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (le) begin
        age <= age + AGE_W'(1);
      end else if (left_le) begin
        val <= v;
        age <= '0;
      end else begin
        val <= left_val;
        age <= left_age + AGE_W'(1);
      end
    end else if (ctl.rem && valid && (val >= r)) begin
      val <= right_val;
      age <= right_age;
    end
  end

endmodule

// ===== rtl/sliding_window_median_cost.sv =====
// Sliding-window median cost: each sample on the slave stream enters a window of
// window_length samples held in sorted order by a row of cells, one cell per
// slot. Once the window is full, each sample yields one transaction on the master
// stream carrying the lower median and the sum of absolute deviations from it,
// after which the oldest sample leaves the window. Each item passes through two
// states: ST_IDLE for the sorted insert across the cell row and ST_EMIT for the
// result and the sorted removal; ST_EMIT waits while a previous result is held.
// No new sample is taken before it ends. A window_length of zero acts as one and
// values above WINDOW_MAX act as WINDOW_MAX. Writing window_length empties the window.
module sliding_window_median_cost #(
  parameter int WINDOW_MAX = swmc_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [swmc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // sample [30:0]
  input  logic [swmc_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // deviation_cost [38:0], median_value [69:39]
  output logic [swmc_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int SW    = swmc_pkg::SAMPLE_W;
  localparam int AGE_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = (SW + AGE_W > swmc_pkg::COST_W) ? SW + AGE_W : swmc_pkg::COST_W;

  swmc_pkg::state_t    state, state_next;
  swmc_pkg::cell_ctl_t ctl;

  logic [swmc_pkg::CFG_W-1:0] window_length;
  logic [CNT_W-1:0]           len_eff;
  logic [CNT_W-1:0]           n, n_next;
  logic [SUM_W-1:0]           lsum, lsum_next, tsum, tsum_next;
  logic [CNT_W-1:0]           h, hr;
  logic                       odd, full, out_free, emit_go, accept;

  logic [SW-1:0]    v;
  logic [SW-1:0]    cval [WINDOW_MAX];
  logic [AGE_W-1:0] cage [WINDOW_MAX];
  logic             cle  [WINDOW_MAX];
  logic             cvalid [WINDOW_MAX];

  logic [SW-1:0] med, nxt, rmval;
  logic          le_h, le_m, inlow;
  logic [SUM_W-1:0] cost;

  assign v        = s_tdata[SW-1:0];
  assign accept   = s_tvalid && s_tready;
  assign odd      = n[0];
  assign h        = CNT_W'(({1'b0, n} + (CNT_W + 1)'(1)) >> 1);
  assign hr       = n >> 1;
  assign full     = (n == len_eff);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (window_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (int'(window_length) > WINDOW_MAX) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(window_length);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
      assign cvalid[gi] = CNT_W'(gi) < n;
      swmc_cell #(.AGE_W(AGE_W)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .v         (v),
        .r         (rmval),
        .valid     (cvalid[gi]),
        .left_le   ((gi == 0) ? 1'b1 : cle[(gi == 0) ? 0 : gi - 1]),
        .left_val  ((gi == 0) ? '0 : cval[(gi == 0) ? 0 : gi - 1]),
        .left_age  ((gi == 0) ? '0 : cage[(gi == 0) ? 0 : gi - 1]),
        .right_val ((gi == WINDOW_MAX - 1) ? '0 : cval[(gi == WINDOW_MAX - 1) ? gi : gi + 1]),
        .right_age ((gi == WINDOW_MAX - 1) ? '0 : cage[(gi == WINDOW_MAX - 1) ? gi : gi + 1]),
        .val       (cval[gi]),
        .age       (cage[gi]),
        .le        (cle[gi])
      );
    end
  endgenerate

  always_comb begin
    med   = '0;
    nxt   = '0;
    rmval = '0;
    le_h  = 1'b0;
    le_m  = 1'b0;
    inlow = 1'b0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (CNT_W'(i) == h - CNT_W'(1)) begin
        med  = med | cval[i];
        le_m = le_m | cle[i];
      end
      if (CNT_W'(i) == h) begin
        nxt  = nxt | cval[i];
        le_h = le_h | cle[i];
      end
      if (cvalid[i] && (CNT_W'(cage[i]) == n - CNT_W'(1))) begin
        rmval = rmval | cval[i];
      end
    end
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (cvalid[i] && (CNT_W'(i) < hr) && (cval[i] == rmval)) begin
        inlow = 1'b1;
      end
    end
  end

  assign cost = tsum - (lsum << 1) + (odd ? SUM_W'(med) : '0);

  always_comb begin
    state_next = state;
    case (state)
      swmc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = swmc_pkg::ST_EMIT;
        end
      end
      swmc_pkg::ST_EMIT: begin
        if (!full || out_free) begin
          state_next = swmc_pkg::ST_IDLE;
        end
      end
      default: state_next = swmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    emit_go  = 1'b0;
    case (state)
      swmc_pkg::ST_IDLE: s_tready = 1'b1;
      swmc_pkg::ST_EMIT: emit_go  = full && out_free;
      default: ;
    endcase
    ctl.ins = accept;
    ctl.rem = emit_go;
  end

  always_comb begin
    n_next    = n;
    lsum_next = lsum;
    tsum_next = tsum;
    if (accept) begin
      n_next    = n + CNT_W'(1);
      tsum_next = tsum + SUM_W'(v);
      if (odd) begin
        lsum_next = le_m ? lsum : lsum - SUM_W'(med) + SUM_W'(v);
      end else begin
        lsum_next = le_h ? lsum + SUM_W'(nxt) : lsum + SUM_W'(v);
      end
    end else if (emit_go) begin
      n_next    = n - CNT_W'(1);
      tsum_next = tsum - SUM_W'(rmval);
      if (inlow) begin
        lsum_next = odd ? lsum - SUM_W'(rmval) : lsum - SUM_W'(rmval) + SUM_W'(nxt);
      end else if (odd) begin
        lsum_next = lsum - SUM_W'(med);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= swmc_pkg::ST_IDLE;
      window_length <= swmc_pkg::CFG_W'(1);
      n             <= '0;
      lsum          <= '0;
      tsum          <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        window_length <= cfg_data;
        n             <= '0;
        lsum          <= '0;
        tsum          <= '0;
      end else begin
        n    <= n_next;
        lsum <= lsum_next;
        tsum <= tsum_next;
      end
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata <= {(swmc_pkg::OUT_TDATA_W - SW - swmc_pkg::COST_W)'(0), med,
                  cost[swmc_pkg::COST_W-1:0]};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(n) <= WINDOW_MAX) else $error("window count above capacity");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == swmc_pkg::ST_EMIT |-> n != '0) else $error("result state with empty window");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == swmc_pkg::ST_EMIT))
    else $error("result raised outside result state");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    emit_go && !cfg_we |=> n == $past(n) - CNT_W'(1))
    else $error("removal did not shrink window");

endmodule

// ===== tb/sliding_window_median_cost_tb.sv =====
`timescale 1ns / 100ps

module sliding_window_median_cost_tb;

  localparam int WMAX        = swmc_pkg::WINDOW_MAX_DEF;
  localparam int COST_W      = swmc_pkg::COST_W;
  localparam int SAMPLE_W    = swmc_pkg::SAMPLE_W;
  localparam int CFG_W       = swmc_pkg::CFG_W;
  localparam int IN_TDATA_W  = swmc_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = swmc_pkg::OUT_TDATA_W;

  typedef struct packed {
    logic [SAMPLE_W-1:0] median;
    logic [COST_W-1:0]   cost;
  } med_result_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    bit                  known;
    logic [COST_W-1:0]   cost;
    logic [SAMPLE_W-1:0] median;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int errors = 0;
  med_result_t pending_q[$];
  logic [SAMPLE_W-1:0] arrivals_q[$];
  logic [SAMPLE_W-1:0] sorted_q[$];
  int win_len = 1;
  bit hold_off = 1'b0;
  bit stall_mode = 1'b0;

  sliding_window_median_cost i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int clamp_len(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > WMAX) return WMAX;
    return int'(v);
  endfunction

  // Inserts a sample, returns whether the window is full; if so, sets r and drops the oldest.
  function automatic bit predict_median_cost(input logic [SAMPLE_W-1:0] v,
                                             output med_result_t r);
    int pos;
    int n;
    int half;
    logic [COST_W-1:0] acc;
    logic [SAMPLE_W-1:0] med;
    logic [SAMPLE_W-1:0] old;
    pos = 0;
    arrivals_q.push_back(v);
    while (pos < sorted_q.size() && sorted_q[pos] <= v) pos++;
    sorted_q.insert(pos, v);
    n = sorted_q.size();
    if (n < win_len) return 1'b0;
    half = (n + 1) / 2;
    med = sorted_q[half - 1];
    acc = '0;
    foreach (sorted_q[i]) begin
      if (sorted_q[i] > med) acc += COST_W'(sorted_q[i] - med);
      else acc += COST_W'(med - sorted_q[i]);
    end
    r.cost = acc;
    r.median = med;
    old = arrivals_q.pop_front();
    foreach (sorted_q[i]) begin
      if (sorted_q[i] == old) begin
        sorted_q.delete(i);
        break;
      end
    end
    return 1'b1;
  endfunction

  task automatic write_window_length(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len = clamp_len(v);
    arrivals_q.delete();
    sorted_q.delete();
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit known,
                             input logic [COST_W-1:0] tcost,
                             input logic [SAMPLE_W-1:0] tmed);
    med_result_t r;
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, v};
    do @(posedge clk); while (!s_tready);
    if (predict_median_cost(v, r)) begin
      if (known && (r.cost != tcost || r.median != tmed))
        report_mismatch("directed row disagrees with predictor");
      pending_q.push_back(r);
    end
  endtask

  task automatic drain_results();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_burst(input int count, input int max_len);
    int k;
    int gap;
    logic [SAMPLE_W-1:0] v;
    k = 0;
    while (k < count) begin
      repeat ($urandom_range(1, max_len)) begin
        if (k < count) begin
          case ($urandom_range(0, 5))
            0: v = {SAMPLE_W{1'b1}};
            1: v = '0;
            2: v = SAMPLE_W'($urandom_range(0, 15));
            default: v = SAMPLE_W'($urandom);
          endcase
          send_sample(v, 1'b0, '0, '0);
          k++;
        end
      end
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    med_result_t got;
    med_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = med_result_t'(m_tdata[COST_W+SAMPLE_W-1:0]);
      if (pending_q.size() == 0) begin
        report_mismatch("transaction with no expected result");
      end else begin
        want = pending_q.pop_front();
        if (got.cost !== want.cost)
          report_mismatch($sformatf("cost %0d expected %0d", got.cost, want.cost));
        if (got.median !== want.median)
          report_mismatch($sformatf("median %0d expected %0d", got.median, want.median));
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    logic [SAMPLE_W-1:0] maxv;
    int settings[$];
    maxv = {SAMPLE_W{1'b1}};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset the window holds one sample, so each result is that sample at zero cost.
    rows = '{
      '{'0, 1'b1, '0, '0},
      '{maxv, 1'b1, '0, maxv},
      '{SAMPLE_W'(1), 1'b1, '0, SAMPLE_W'(1)},
      '{SAMPLE_W'(31'h5555_5555), 1'b1, '0, SAMPLE_W'(31'h5555_5555)},
      '{SAMPLE_W'(31'h2AAA_AAAA), 1'b1, '0, SAMPLE_W'(31'h2AAA_AAAA)}
    };
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].cost, rows[i].median);
    s_tvalid <= 1'b0;
    drain_results();

    // Zero acts as one.
    write_window_length('0);
    row = '{maxv, 1'b1, '0, maxv};
    send_sample(row.sample, row.known, row.cost, row.median);
    s_tvalid <= 1'b0;
    drain_results();

    // Two samples: lower median is the smaller one, cost the difference.
    write_window_length(CFG_W'(2));
    rows = '{
      '{'0, 1'b0, '0, '0},
      '{maxv, 1'b1, COST_W'(maxv), '0},
      '{maxv, 1'b1, '0, maxv},
      '{SAMPLE_W'(5), 1'b1, COST_W'(maxv - 5), SAMPLE_W'(5)},
      '{SAMPLE_W'(5), 1'b1, '0, SAMPLE_W'(5)}
    };
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].cost, rows[i].median);
    s_tvalid <= 1'b0;
    drain_results();

    // Three equal samples, then a smaller sample entering the full window.
    write_window_length(CFG_W'(3));
    rows = '{
      '{SAMPLE_W'(7), 1'b0, '0, '0},
      '{SAMPLE_W'(7), 1'b0, '0, '0},
      '{SAMPLE_W'(7), 1'b1, '0, SAMPLE_W'(7)},
      '{SAMPLE_W'(1), 1'b1, COST_W'(6), SAMPLE_W'(7)}
    };
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].cost, rows[i].median);
    s_tvalid <= 1'b0;
    drain_results();

    settings = '{511, 5, 4, 1, 16, 2, 9};
    foreach (settings[i]) begin
      write_window_length(CFG_W'(settings[i]));
      if (i == 0) begin
        // Long receiver hold-off while the window fills and a held result back-pressures the input.
        fork
          random_burst(win_len + 30, 40);
          begin
            hold_off = 1'b1;
            repeat (4 * WMAX + 200) @(posedge clk);
            hold_off = 1'b0;
          end
        join
      end else begin
        random_burst(settings[i] > 64 ? win_len + 40 : 50, 12);
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
